// ----- rtl/core/ugns_pkg.sv -----
package ugns_pkg;

	// Field widths
	localparam int ID_W      = 6;
	localparam int POS_W     = 20;
	localparam int RAD_W     = 19;
	localparam int SIZE_W    = 19;
	localparam int CNT_W     = 5;
	localparam int NIDX_W    = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 19;

	// Default sizing
	localparam int DEF_MAX_AGENTS     = 64;
	localparam int DEF_MAX_COLS       = 16;
	localparam int DEF_MAX_ROWS       = 16;
	localparam int DEF_SLOTS_PER_CELL = 8;

	// At most this many neighbors per query, so the final result stays in range
	localparam int MAX_NEIGHBORS = 63;

	// Register reset values
	localparam logic [CNT_W-1:0]  RST_COLUMN_COUNT = CNT_W'(16);
	localparam logic [CNT_W-1:0]  RST_ROW_COUNT    = CNT_W'(16);
	localparam logic [SIZE_W-1:0] RST_SPACE_WIDTH  = SIZE_W'(16384);
	localparam logic [SIZE_W-1:0] RST_SPACE_HEIGHT = SIZE_W'(16384);
	localparam logic [SIZE_W-1:0] RST_CELL_WIDTH   = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0] RST_CELL_HEIGHT  = SIZE_W'(1024);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_MOVE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMN_COUNT = 3'd0,
		REG_ROW_COUNT    = 3'd1,
		REG_SPACE_WIDTH  = 3'd2,
		REG_SPACE_HEIGHT = 3'd3,
		REG_CELL_WIDTH   = 3'd4,
		REG_CELL_HEIGHT  = 3'd5
	} reg_idx_t;

	// Index width for a store of n entries, never below one bit
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ----- rtl/core/ugns_axis_div.sv -----
module ugns_axis_div #(
	parameter int MAX_DIM = ugns_pkg::DEF_MAX_COLS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [ugns_pkg::POS_W:0]        pos,
	input  logic [ugns_pkg::SIZE_W-1:0]            span,
	input  logic [ugns_pkg::SIZE_W-1:0]            size,
	input  logic [ugns_pkg::idx_w(MAX_DIM)-1:0]    lim,
	output logic                                   done,
	output logic [ugns_pkg::idx_w(MAX_DIM)-1:0]    cell_idx
);
	import ugns_pkg::*;

	localparam int DIM_W = idx_w(MAX_DIM);
	localparam int QW    = $clog2(MAX_DIM + 1);
	localparam int NW    = POS_W + 3;
	localparam int RW    = NW + QW;
	localparam int KW    = $clog2(QW + 1);

	logic signed [NW-1:0] num;
	logic [SIZE_W:0]      d2;
	logic [RW-1:0]        num_u;
	logic [RW-1:0]        dtop;
	logic                 run_q;
	logic                 done_q;
	logic [KW-1:0]        k_q;
	logic [RW-1:0]        rem_q;
	logic [RW-1:0]        dsh_q;
	logic [QW-1:0]        q_q;
	logic [DIM_W-1:0]     lim_q;
	logic [DIM_W-1:0]     cell_q;
	logic                 ge;
	logic [QW-1:0]        qn;
	logic                 done_set;

	// numerator 2p + span, divisor 2 * cell size
	assign num   = ($signed({{2{pos[POS_W]}}, pos}) <<< 1)
	             + $signed({{(NW - SIZE_W){1'b0}}, span});
	assign d2    = {((size == '0) ? SIZE_W'(1) : size), 1'b0};
	assign num_u = RW'(unsigned'(num));
	assign dtop  = RW'(d2) << QW;
	assign ge    = rem_q >= dsh_q;
	assign qn    = QW'({q_q, ge});

	// finish at once when the coordinate clamps, else after the last quotient bit
	assign done_set = start ? ((num < 0) || (num_u >= dtop)) : (run_q && (k_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
			rem_q  <= '0;
			dsh_q  <= '0;
			q_q    <= '0;
			lim_q  <= '0;
			cell_q <= '0;
		end else begin
			done_q <= done_set;
			if (start) begin
				lim_q <= lim;
				if (num < 0) begin
					cell_q <= '0;
				end else if (num_u >= dtop) begin
					cell_q <= lim;
				end else begin
					rem_q <= num_u;
					dsh_q <= RW'(d2) << (QW - 1);
					q_q   <= '0;
					k_q   <= KW'(QW - 1);
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				// one quotient bit a cycle, most significant first
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				q_q   <= qn;
				k_q   <= k_q - KW'(1);
				if (k_q == '0) begin
					run_q  <= 1'b0;
					cell_q <= (qn > QW'(lim_q)) ? lim_q : DIM_W'(qn);
				end
			end
		end
	end

	assign done     = done_q;
	assign cell_idx = cell_q;

endmodule

// ----- rtl/core/ugns_square.sv -----
module ugns_square #(
	parameter int W = ugns_pkg::POS_W + 1
) (
	input  logic                clk,
	input  logic signed [W-1:0] a,
	output logic [2*W-1:0]      sq
);
	logic [W-1:0]   mag;
	logic [2*W-1:0] sq_q;

	assign mag = a[W-1] ? W'(-a) : W'(a);

	always_ff @(posedge clk) begin
		sq_q <= mag * mag;
	end

	assign sq = sq_q;

endmodule

// ----- rtl/core/uniform_grid_neighbor_search.sv -----
// Uniform grid neighbor search. Agents live in per-cell slot lists of a grid
// centred on the origin; the block adds, moves and clears agents and answers
// radius queries. Raise start while busy is low to transfer one operation;
// busy stays high until the operation has finished. Every result appears on
// the result ports for exactly one cycle with result_valid high and must be
// taken then: there is no way to hold results off. Add, move and clear give a
// single result with last set (status flags a full target cell). A query
// gives one result per neighbor found (neighbor_valid set, neighbor_index
// counting from 1) and then a closing result with last set and the total.
// Add and move first run 2 or 4 cell coordinate divisions on the shared
// bit-serial divider, each cut short when the coordinate clamps to the grid
// edge, and then walk each touched slot list. A query runs 4 divisions and
// then walks each covered cell and the agents listed in it, using the single
// slot memory read port and the shared squarer.
// Configuration writes are taken at any edge with cfg_we high and must only be
// issued while busy is low and no result is pending.
module uniform_grid_neighbor_search #(
	parameter int MAX_AGENTS     = ugns_pkg::DEF_MAX_AGENTS,
	parameter int MAX_COLS       = ugns_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS       = ugns_pkg::DEF_MAX_ROWS,
	parameter int SLOTS_PER_CELL = ugns_pkg::DEF_SLOTS_PER_CELL
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          operation,
	input  logic [ugns_pkg::ID_W-1:0]           agent_id,
	input  logic signed [ugns_pkg::POS_W-1:0]   pos_x,
	input  logic signed [ugns_pkg::POS_W-1:0]   pos_y,
	input  logic signed [ugns_pkg::POS_W-1:0]   old_x,
	input  logic signed [ugns_pkg::POS_W-1:0]   old_y,
	input  logic [ugns_pkg::RAD_W-1:0]          query_radius,
	output logic                                result_valid,
	output logic                                status,
	output logic                                neighbor_valid,
	output logic [ugns_pkg::ID_W-1:0]           neighbor_id,
	output logic [ugns_pkg::NIDX_W-1:0]         neighbor_index,
	output logic                                last,
	input  logic                                cfg_we,
	input  logic [ugns_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ugns_pkg::CFG_W-1:0]          cfg_data
);
	import ugns_pkg::*;

	localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int DIM_W   = idx_w(MAX_DIM);
	localparam int CELLS   = MAX_COLS * MAX_ROWS;
	localparam int CELL_W  = idx_w(CELLS);
	localparam int SLOT_W  = idx_w(SLOTS_PER_CELL);
	localparam int FILL_W  = $clog2(SLOTS_PER_CELL + 1);
	localparam int AGENT_W = idx_w(MAX_AGENTS);
	localparam int SA_W    = CELL_W + SLOT_W;
	localparam int MUL_W   = 2 * DIM_W + 2;
	localparam int D_W     = POS_W + 1;
	localparam int SQ_W    = 2 * D_W;

	typedef enum logic [4:0] {
		S_IDLE, S_DIV_GO, S_DIV_WAIT, S_NCELL, S_OCELL,
		S_U_FILL, S_U_FILLW, S_U_SLOT, S_U_SLOTW, S_U_DONE,
		S_L_FILL, S_L_FILLW, S_L_SLOT, S_L_SLOTW, S_L_APPEND,
		S_Q_CELL, S_Q_FILL, S_Q_FILLW, S_Q_SLOT, S_Q_SLOTW,
		S_Q_POS, S_Q_POSW, S_Q_DX, S_Q_DY, S_DONE
	} state_t;

	// Configuration
	logic [CNT_W-1:0]  column_count_q;
	logic [CNT_W-1:0]  row_count_q;
	logic [SIZE_W-1:0] space_width_q;
	logic [SIZE_W-1:0] space_height_q;
	logic [SIZE_W-1:0] cell_width_q;
	logic [SIZE_W-1:0] cell_height_q;
	logic [DIM_W-1:0]  col_lim;
	logic [DIM_W-1:0]  row_lim;
	logic [DIM_W:0]    cols_eff;

	// Sequencer
	state_t               state_q;
	op_t                  op_q;
	logic [ID_W-1:0]      id_q;
	logic signed [POS_W-1:0] px_q, py_q;
	logic signed [D_W-1:0]   xa_q, ya_q, xb_q, yb_q;
	logic [RAD_W-1:0]     radius_q;
	logic [1:0]           job_q;
	logic [DIM_W-1:0]     ca_q, ra_q, cb_q, rb_q;
	logic [DIM_W-1:0]     c_q, w_q;
	logic [CELL_W-1:0]    nc_q, cell_q;
	logic [FILL_W-1:0]    n_q, i_q, j_q;
	logic [ID_W-1:0]      agent_q;
	logic [SQ_W-1:0]      rr_q, dx2_q;
	logic [NIDX_W-1:0]    found_q;
	logic                 st_q;
	logic [CELLS-1:0]     fill_vld_q;

	// Result registers
	logic              res_vld_q;
	logic              status_q;
	logic              nvalid_q;
	logic [ID_W-1:0]   nid_q;
	logic [NIDX_W-1:0] nidx_q;
	logic              last_q;

	// Memories
	logic [POS_W-1:0]  pos_x_mem [MAX_AGENTS];
	logic [POS_W-1:0]  pos_y_mem [MAX_AGENTS];
	logic [ID_W-1:0]   slot_mem  [2**SA_W];
	logic [FILL_W-1:0] fill_mem  [CELLS];
	logic signed [POS_W-1:0] pos_x_rd, pos_y_rd;
	logic [ID_W-1:0]   slot_rd;
	logic [FILL_W-1:0] fill_rd;
	logic              fill_vld_rd;
	logic [FILL_W-1:0] fill_n;

	// Shared units
	logic                  div_start, div_done;
	logic signed [D_W-1:0] div_pos;
	logic [SIZE_W-1:0]     div_span, div_size;
	logic [DIM_W-1:0]      div_lim, div_cell;
	logic signed [D_W-1:0] sq_in;
	logic [SQ_W-1:0]       sq_out;

	// Glue
	logic              accept;
	logic              id_ok;
	logic [DIM_W-1:0]  mrow, mcol;
	logic [MUL_W-1:0]  cell_prod;
	logic [CELL_W-1:0] cell_calc;
	logic              more_slots;
	logic              walk_end;
	logic [DIM_W-1:0]  nxt_c, nxt_w;
	logic [SQ_W:0]     dist2;
	logic              hit;
	logic              res_set;
	logic              slot_we, fill_we;
	logic [ID_W-1:0]   slot_wdata;
	logic [SLOT_W-1:0] slot_widx;
	logic [FILL_W-1:0] fill_wdata;

	function automatic logic [DIM_W-1:0] lim_of(input logic [CNT_W-1:0] c, input int mx);
		int v;
		if (c == '0) begin
			v = 0;
		end else if (int'(c) > mx) begin
			v = mx - 1;
		end else begin
			v = int'(c) - 1;
		end
		return DIM_W'(v);
	endfunction

	assign col_lim  = lim_of(column_count_q, MAX_COLS);
	assign row_lim  = lim_of(row_count_q, MAX_ROWS);
	assign cols_eff = (DIM_W + 1)'(col_lim) + (DIM_W + 1)'(1);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign id_ok  = 32'(agent_id) < MAX_AGENTS;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= RST_COLUMN_COUNT;
			row_count_q    <= RST_ROW_COUNT;
			space_width_q  <= RST_SPACE_WIDTH;
			space_height_q <= RST_SPACE_HEIGHT;
			cell_width_q   <= RST_CELL_WIDTH;
			cell_height_q  <= RST_CELL_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMN_COUNT: column_count_q <= cfg_data[CNT_W-1:0];
				REG_ROW_COUNT:    row_count_q    <= cfg_data[CNT_W-1:0];
				REG_SPACE_WIDTH:  space_width_q  <= cfg_data[SIZE_W-1:0];
				REG_SPACE_HEIGHT: space_height_q <= cfg_data[SIZE_W-1:0];
				REG_CELL_WIDTH:   cell_width_q   <= cfg_data[SIZE_W-1:0];
				REG_CELL_HEIGHT:  cell_height_q  <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Division jobs: even jobs are columns, odd jobs rows; the upper job bit
	// picks the second point (move: old position, query: far corner).
	always_comb begin
		if (!job_q[0]) begin
			div_pos  = job_q[1] ? xb_q : xa_q;
			div_span = space_width_q;
			div_size = cell_width_q;
			div_lim  = col_lim;
		end else begin
			div_pos  = job_q[1] ? yb_q : ya_q;
			div_span = space_height_q;
			div_size = cell_height_q;
			div_lim  = row_lim;
		end
	end

	assign div_start = (state_q == S_DIV_GO);

	ugns_axis_div #(
		.MAX_DIM (MAX_DIM)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.pos      (div_pos),
		.span     (div_span),
		.size     (div_size),
		.lim      (div_lim),
		.done     (div_done),
		.cell_idx (div_cell)
	);

	// Squarer input: radius while dividing, then dx and dy of one agent
	always_comb begin
		unique case (state_q)
			S_Q_POSW: sq_in = D_W'(pos_x_rd) - D_W'(px_q);
			S_Q_DX:   sq_in = D_W'(pos_y_rd) - D_W'(py_q);
			default:  sq_in = $signed(D_W'(radius_q));
		endcase
	end

	ugns_square #(
		.W (D_W)
	) u_sq (
		.clk (clk),
		.a   (sq_in),
		.sq  (sq_out)
	);

	assign dist2 = (SQ_W + 1)'(dx2_q) + (SQ_W + 1)'(sq_out);
	assign hit   = dist2 < (SQ_W + 1)'(rr_q);

	// Raise the result strobe for a new neighbor or the closing result
	assign res_set = (state_q == S_DONE)
	              || ((state_q == S_Q_DY) && hit && (32'(found_q) < MAX_NEIGHBORS));

	// Cell index: row * columns + column, one small multiply
	always_comb begin
		unique case (state_q)
			S_NCELL: begin
				mrow = ra_q;
				mcol = ca_q;
			end
			S_OCELL: begin
				mrow = rb_q;
				mcol = cb_q;
			end
			default: begin
				mrow = w_q;
				mcol = c_q;
			end
		endcase
	end

	assign cell_prod = MUL_W'(mrow) * MUL_W'(cols_eff) + MUL_W'(mcol);
	assign cell_calc = CELL_W'(cell_prod);

	// Query walk: columns outer, rows inner
	assign fill_n     = fill_vld_rd ? fill_rd : '0;
	assign more_slots = ((FILL_W + 1)'(i_q) + (FILL_W + 1)'(1)) < (FILL_W + 1)'(n_q);
	assign walk_end   = (w_q >= rb_q) && (c_q >= cb_q);
	assign nxt_w      = (w_q >= rb_q) ? ra_q : w_q + DIM_W'(1);
	assign nxt_c      = (w_q >= rb_q) ? c_q + DIM_W'(1) : c_q;

	// Memory write controls
	always_comb begin
		slot_we    = 1'b0;
		slot_widx  = SLOT_W'(j_q);
		slot_wdata = slot_rd;
		fill_we    = 1'b0;
		fill_wdata = j_q;
		unique case (state_q)
			S_U_SLOTW: begin
				slot_we = (slot_rd != id_q);
			end
			S_U_DONE: begin
				fill_we = 1'b1;
			end
			S_L_APPEND: begin
				slot_we    = (32'(n_q) < SLOTS_PER_CELL);
				slot_widx  = SLOT_W'(n_q);
				slot_wdata = id_q;
				fill_we    = (32'(n_q) < SLOTS_PER_CELL);
				fill_wdata = n_q + FILL_W'(1);
			end
			default: ;
		endcase
	end

	// Agent positions, written when an add or move is transferred
	always_ff @(posedge clk) begin
		if (accept && (operation == OP_ADD || operation == OP_MOVE) && id_ok) begin
			pos_x_mem[AGENT_W'(agent_id)] <= pos_x;
			pos_y_mem[AGENT_W'(agent_id)] <= pos_y;
		end
		pos_x_rd <= pos_x_mem[AGENT_W'(agent_q)];
		pos_y_rd <= pos_y_mem[AGENT_W'(agent_q)];
	end

	// Slot lists
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[{cell_q, slot_widx}] <= slot_wdata;
		end
		slot_rd <= slot_mem[{cell_q, SLOT_W'(i_q)}];
	end

	// Fill counts; an entry without its valid bit reads as zero
	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[cell_q] <= fill_wdata;
		end
		fill_rd     <= fill_mem[cell_q];
		fill_vld_rd <= fill_vld_q[cell_q];
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_ADD;
			id_q       <= '0;
			px_q       <= '0;
			py_q       <= '0;
			xa_q       <= '0;
			ya_q       <= '0;
			xb_q       <= '0;
			yb_q       <= '0;
			radius_q   <= '0;
			job_q      <= '0;
			ca_q       <= '0;
			ra_q       <= '0;
			cb_q       <= '0;
			rb_q       <= '0;
			c_q        <= '0;
			w_q        <= '0;
			nc_q       <= '0;
			cell_q     <= '0;
			n_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			agent_q    <= '0;
			rr_q       <= '0;
			dx2_q      <= '0;
			found_q    <= '0;
			st_q       <= 1'b0;
			fill_vld_q <= '0;
			res_vld_q  <= 1'b0;
			status_q   <= 1'b0;
			nvalid_q   <= 1'b0;
			nid_q      <= '0;
			nidx_q     <= '0;
			last_q     <= 1'b0;
		end else begin
			res_vld_q <= res_set;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= op_t'(operation);
						id_q     <= agent_id;
						px_q     <= pos_x;
						py_q     <= pos_y;
						radius_q <= query_radius;
						found_q  <= '0;
						st_q     <= 1'b0;
						job_q    <= '0;
						if (operation == OP_QUERY) begin
							xa_q <= D_W'(pos_x) - D_W'(query_radius);
							ya_q <= D_W'(pos_y) - D_W'(query_radius);
							xb_q <= D_W'(pos_x) + D_W'(query_radius);
							yb_q <= D_W'(pos_y) + D_W'(query_radius);
						end else begin
							xa_q <= D_W'(pos_x);
							ya_q <= D_W'(pos_y);
							xb_q <= D_W'(old_x);
							yb_q <= D_W'(old_y);
						end
						if (operation == OP_CLEAR) begin
							// empty every list at once
							fill_vld_q <= '0;
							state_q    <= S_DONE;
						end else if (operation == OP_QUERY || id_ok) begin
							state_q <= S_DIV_GO;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					rr_q <= sq_out;
					if (div_done) begin
						unique case (job_q)
							2'd0: ca_q <= div_cell;
							2'd1: ra_q <= div_cell;
							2'd2: cb_q <= div_cell;
							default: rb_q <= div_cell;
						endcase
						job_q <= job_q + 2'd1;
						if (op_q == OP_ADD && job_q == 2'd1) begin
							state_q <= S_NCELL;
						end else if (job_q == 2'd3) begin
							if (op_q == OP_QUERY) begin
								c_q     <= ca_q;
								w_q     <= ra_q;
								state_q <= S_Q_CELL;
							end else begin
								state_q <= S_NCELL;
							end
						end else begin
							state_q <= S_DIV_GO;
						end
					end
				end
				S_NCELL: begin
					nc_q   <= cell_calc;
					cell_q <= cell_calc;
					state_q <= (op_q == OP_ADD) ? S_L_FILL : S_OCELL;
				end
				S_OCELL: begin
					if (cell_calc == nc_q) begin
						state_q <= S_DONE;
					end else begin
						cell_q  <= cell_calc;
						state_q <= S_U_FILL;
					end
				end
				// remove the agent from its old cell, keeping order
				S_U_FILL: begin
					state_q <= S_U_FILLW;
				end
				S_U_FILLW: begin
					n_q     <= fill_n;
					i_q     <= '0;
					j_q     <= '0;
					state_q <= (fill_n == '0) ? S_U_DONE : S_U_SLOT;
				end
				S_U_SLOT: begin
					state_q <= S_U_SLOTW;
				end
				S_U_SLOTW: begin
					if (slot_rd != id_q) begin
						j_q <= j_q + FILL_W'(1);
					end
					i_q     <= i_q + FILL_W'(1);
					state_q <= more_slots ? S_U_SLOT : S_U_DONE;
				end
				S_U_DONE: begin
					fill_vld_q[cell_q] <= 1'b1;
					cell_q  <= nc_q;
					state_q <= S_L_FILL;
				end
				// list the agent in its new cell unless already there
				S_L_FILL: begin
					state_q <= S_L_FILLW;
				end
				S_L_FILLW: begin
					n_q     <= fill_n;
					i_q     <= '0;
					state_q <= (fill_n == '0) ? S_L_APPEND : S_L_SLOT;
				end
				S_L_SLOT: begin
					state_q <= S_L_SLOTW;
				end
				S_L_SLOTW: begin
					i_q <= i_q + FILL_W'(1);
					if (slot_rd == id_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= more_slots ? S_L_SLOT : S_L_APPEND;
					end
				end
				S_L_APPEND: begin
					if (32'(n_q) < SLOTS_PER_CELL) begin
						fill_vld_q[cell_q] <= 1'b1;
					end else begin
						st_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				// query walk over the covered cells
				S_Q_CELL: begin
					cell_q  <= cell_calc;
					state_q <= S_Q_FILL;
				end
				S_Q_FILL: begin
					state_q <= S_Q_FILLW;
				end
				S_Q_FILLW: begin
					n_q <= fill_n;
					i_q <= '0;
					if (fill_n != '0) begin
						state_q <= S_Q_SLOT;
					end else if (walk_end) begin
						state_q <= S_DONE;
					end else begin
						c_q     <= nxt_c;
						w_q     <= nxt_w;
						state_q <= S_Q_CELL;
					end
				end
				S_Q_SLOT: begin
					state_q <= S_Q_SLOTW;
				end
				S_Q_SLOTW: begin
					agent_q <= slot_rd;
					if (32'(slot_rd) < MAX_AGENTS) begin
						state_q <= S_Q_POS;
					end else begin
						i_q <= i_q + FILL_W'(1);
						if (more_slots) begin
							state_q <= S_Q_SLOT;
						end else if (walk_end) begin
							state_q <= S_DONE;
						end else begin
							c_q     <= nxt_c;
							w_q     <= nxt_w;
							state_q <= S_Q_CELL;
						end
					end
				end
				S_Q_POS: begin
					state_q <= S_Q_POSW;
				end
				S_Q_POSW: begin
					state_q <= S_Q_DX;
				end
				S_Q_DX: begin
					dx2_q   <= sq_out;
					state_q <= S_Q_DY;
				end
				S_Q_DY: begin
					if (hit && 32'(found_q) < MAX_NEIGHBORS) begin
						found_q   <= found_q + NIDX_W'(1);
						status_q  <= 1'b0;
						nvalid_q  <= 1'b1;
						nid_q     <= agent_q;
						nidx_q    <= found_q + NIDX_W'(1);
						last_q    <= 1'b0;
					end
					i_q <= i_q + FILL_W'(1);
					if (more_slots) begin
						state_q <= S_Q_SLOT;
					end else if (walk_end) begin
						state_q <= S_DONE;
					end else begin
						c_q     <= nxt_c;
						w_q     <= nxt_w;
						state_q <= S_Q_CELL;
					end
				end
				S_DONE: begin
					// closing result of every operation
					status_q  <= st_q;
					nvalid_q  <= 1'b0;
					nid_q     <= '0;
					nidx_q    <= found_q;
					last_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid   = res_vld_q;
	assign status         = status_q;
	assign neighbor_valid = nvalid_q;
	assign neighbor_id    = nid_q;
	assign neighbor_index = nidx_q;
	assign last           = last_q;

endmodule

// ----- rtl/core/ugns_checker.sv -----
module ugns_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             result_valid,
	input logic                             status,
	input logic                             neighbor_valid,
	input logic [ugns_pkg::NIDX_W-1:0]      neighbor_index,
	input logic                             last
);

	// a transfer always makes the block busy in the following cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transfer");

	// the closing result shows while the block is already free again
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy && !neighbor_valid)
		else $error("closing result while busy or flagged as neighbor");

	// a result that is not the last is a neighbor of a running query
	a_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy && neighbor_valid && !status)
		else $error("intermediate result malformed");

	// neighbors count from one
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && neighbor_valid |-> neighbor_index != '0)
		else $error("neighbor index zero");

endmodule

bind uniform_grid_neighbor_search ugns_checker u_ugns_checker (.*);

// ----- tb/uniform_grid_neighbor_search_tb.sv -----
`timescale 1ns / 100ps
module uniform_grid_neighbor_search_tb;
	import ugns_pkg::*;

	localparam int AGENTS   = DEF_MAX_AGENTS;
	localparam int COLS     = DEF_MAX_COLS;
	localparam int ROWS     = DEF_MAX_ROWS;
	localparam int SLOTS    = DEF_SLOTS_PER_CELL;
	localparam int CELLS    = COLS * ROWS;
	// cycles to let the block settle before touching a register
	localparam int SETTLE   = 8;
	// cycles with no transfer and no result before the run is abandoned
	localparam int WATCHDOG = 60000;

	typedef enum logic [1:0] {
		STEP_OP,
		STEP_CFG,
		STEP_DRAIN
	} step_kind_t;

	// one entry of the stimulus plan: an operation, a register write or a drain point
	typedef struct packed {
		step_kind_t        kind;
		op_t               op;
		logic [5:0]        id;
		logic [19:0]       px;
		logic [19:0]       py;
		logic [19:0]       ox;
		logic [19:0]       oy;
		logic [18:0]       r;
		reg_idx_t          ridx;
		logic [18:0]       rdata;
	} grid_step_t;

	typedef struct packed {
		logic       st;
		logic       nv;
		logic [5:0] nid;
		logic [6:0] nidx;
		logic       lst;
	} grid_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] operation = '0;
	logic [ID_W-1:0] agent_id = '0;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic signed [POS_W-1:0] old_x = '0;
	logic signed [POS_W-1:0] old_y = '0;
	logic [RAD_W-1:0] query_radius = '0;
	logic result_valid;
	logic status;
	logic neighbor_valid;
	logic [ID_W-1:0] neighbor_id;
	logic [NIDX_W-1:0] neighbor_index;
	logic last;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	uniform_grid_neighbor_search uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.agent_id(agent_id),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.old_x(old_x),
		.old_y(old_y),
		.query_radius(query_radius),
		.result_valid(result_valid),
		.status(status),
		.neighbor_valid(neighbor_valid),
		.neighbor_id(neighbor_id),
		.neighbor_index(neighbor_index),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Grid predictor: its own copy of the registers, positions and lists
	// ---------------------------------------------------------------
	int unsigned grid_cols = 16, grid_rows = 16;
	longint grid_sw = 16384, grid_sh = 16384, grid_cw = 1024, grid_ch = 1024;
	longint agent_x [AGENTS];
	longint agent_y [AGENTS];
	int slot_ids [CELLS][SLOTS];
	int slot_fill [CELLS];

	grid_result_t expected_results[$];
	grid_step_t   plan[$];

	int errors = 0;
	int xfer_cnt = 0;
	int result_cnt = 0;
	int neighbor_cnt = 0;
	int full_cnt = 0;
	int cfg_cnt = 0;

	// append to the tail of the expected results
	function automatic void expect_result(grid_result_t res);
		expected_results.insert(expected_results.size(), res);
	endfunction

	// append to the tail of the stimulus plan
	function automatic void plan_step(grid_step_t s);
		plan.insert(plan.size(), s);
	endfunction

	function automatic int unsigned eff_count(int unsigned n, int unsigned mx);
		return (n == 0) ? 1 : ((n > mx) ? mx : n);
	endfunction

	// floor((2p + span) / 2size), negative to 0, clamped to the last cell
	function automatic int unsigned axis_cell(longint p, longint span, longint size,
	                                          int unsigned cnt);
		longint n;
		longint q;
		n = 2 * p + span;
		if (n < 0)
			return 0;
		q = n / (2 * ((size == 0) ? 1 : size));
		if (q > cnt - 1)
			q = cnt - 1;
		return int'(q);
	endfunction

	function automatic int unsigned col_of(longint x);
		return axis_cell(x, grid_sw, grid_cw, eff_count(grid_cols, COLS));
	endfunction

	function automatic int unsigned row_of(longint y);
		return axis_cell(y, grid_sh, grid_ch, eff_count(grid_rows, ROWS));
	endfunction

	function automatic int unsigned cell_of(longint x, longint y);
		return row_of(y) * eff_count(grid_cols, COLS) + col_of(x);
	endfunction

	// append unless already listed; returns 1 when the cell is full
	function automatic logic list_agent(int cidx, int id);
		for (int i = 0; i < slot_fill[cidx]; i++)
			if (slot_ids[cidx][i] == id)
				return 1'b0;
		if (slot_fill[cidx] >= SLOTS)
			return 1'b1;
		slot_ids[cidx][slot_fill[cidx]] = id;
		slot_fill[cidx]++;
		return 1'b0;
	endfunction

	function automatic void unlist_agent(int cidx, int id);
		int j;
		j = 0;
		for (int i = 0; i < slot_fill[cidx]; i++)
			if (slot_ids[cidx][i] != id) begin
				slot_ids[cidx][j] = slot_ids[cidx][i];
				j++;
			end
		slot_fill[cidx] = j;
	endfunction

	function automatic void predict_grid(grid_step_t s);
		grid_result_t res;
		grid_result_t nb;
		longint px, py, ox, oy, rad, rr, dx, dy;
		int unsigned nc, oc, c0, c1, r0, r1, cols, cidx;
		int found, a;
		px = longint'($signed(s.px));
		py = longint'($signed(s.py));
		ox = longint'($signed(s.ox));
		oy = longint'($signed(s.oy));
		rad = longint'(s.r);
		res = '0;
		res.lst = 1'b1;
		unique case (s.op)
			OP_ADD, OP_MOVE: begin
				nc = cell_of(px, py);
				agent_x[s.id] = px;
				agent_y[s.id] = py;
				if (s.op == OP_ADD) begin
					res.st = list_agent(nc, s.id);
				end else begin
					oc = cell_of(ox, oy);
					if (oc != nc) begin
						unlist_agent(oc, s.id);
						res.st = list_agent(nc, s.id);
					end
				end
				if (res.st)
					full_cnt++;
				expect_result(res);
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					slot_fill[i] = 0;
				expect_result(res);
			end
			default: begin
				// walk column-major over the clamped square around the centre
				c0 = col_of(px - rad);
				c1 = col_of(px + rad);
				r0 = row_of(py - rad);
				r1 = row_of(py + rad);
				cols = eff_count(grid_cols, COLS);
				rr = rad * rad;
				found = 0;
				for (int unsigned c = c0; c <= c1; c++)
					for (int unsigned w = r0; w <= r1; w++) begin
						cidx = w * cols + c;
						for (int i = 0; i < slot_fill[cidx]; i++) begin
							a = slot_ids[cidx][i];
							dx = agent_x[a] - px;
							dy = agent_y[a] - py;
							if (dx * dx + dy * dy < rr && found < MAX_NEIGHBORS) begin
								found++;
								nb = '0;
								nb.nv = 1'b1;
								nb.nid = 6'(a);
								nb.nidx = 7'(found);
								expect_result(nb);
							end
						end
					end
				res.nidx = 7'(found);
				expect_result(res);
			end
		endcase
	endfunction

	function automatic void check_field(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endfunction

	// ---------------------------------------------------------------
	// Monitor: check results, mirror register writes, predict transfers
	// ---------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		grid_step_t s;
		grid_result_t e;
		if (arst_n) begin
			if (result_valid) begin
				result_cnt++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: neighbor_id %0d index %0d last %0d",
					       neighbor_id, neighbor_index, last);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (e.nv)
						neighbor_cnt++;
					check_field("status", e.st, status);
					check_field("neighbor_valid", e.nv, neighbor_valid);
					check_field("neighbor_id", e.nid, neighbor_id);
					check_field("neighbor_index", e.nidx, neighbor_index);
					check_field("last", e.lst, last);
				end
			end
			if (cfg_we) begin
				cfg_cnt++;
				unique case (reg_idx_t'(cfg_index))
					REG_COLUMN_COUNT: grid_cols = 32'(cfg_data[CNT_W-1:0]);
					REG_ROW_COUNT:    grid_rows = 32'(cfg_data[CNT_W-1:0]);
					REG_SPACE_WIDTH:  grid_sw = longint'(cfg_data);
					REG_SPACE_HEIGHT: grid_sh = longint'(cfg_data);
					REG_CELL_WIDTH:   grid_cw = longint'(cfg_data);
					REG_CELL_HEIGHT:  grid_ch = longint'(cfg_data);
					default: ;
				endcase
			end
			if (start && !busy) begin
				s = '0;
				s.kind = STEP_OP;
				s.op = op_t'(operation);
				s.id = agent_id;
				s.px = pos_x;
				s.py = pos_y;
				s.ox = old_x;
				s.oy = old_y;
				s.r = query_radius;
				predict_grid(s);
				xfer_cnt++;
			end
			// advance the watchdog only while nothing moves
			if ((start && !busy) || result_valid)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG);
				$display("uniform_grid_neighbor_search_tb: FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Driver: feed the plan at the falling edge with random gaps
	// ---------------------------------------------------------------
	int seen_xfer = 0;
	int gap = 0;
	int quiet = 0;
	int settle = 0;

	function automatic int pick_gap();
		int roll;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 8)
			quiet = $urandom_range(5, 15);
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(negedge clk) begin
		logic n_start;
		logic n_we;
		grid_step_t s;
		if (arst_n) begin
			n_start = start;
			n_we = 1'b0;
			// drop start once the held item has been transferred
			if (start && xfer_cnt != seen_xfer) begin
				seen_xfer = xfer_cnt;
				n_start = 1'b0;
				gap = pick_gap();
			end
			if (!n_start && plan.size() > 0) begin
				s = plan[0];
				if (s.kind == STEP_OP) begin
					if (gap > 0) begin
						gap--;
					end else begin
						operation <= s.op;
						agent_id <= s.id;
						pos_x <= s.px;
						pos_y <= s.py;
						old_x <= s.ox;
						old_y <= s.oy;
						query_radius <= s.r;
						n_start = 1'b1;
						void'(plan.pop_front());
					end
				end else if (expected_results.size() != 0 || busy || start) begin
					settle = 0;
				end else if (settle < SETTLE) begin
					settle++;
				end else begin
					// block idle and drained: write the register or just move on
					settle = 0;
					if (s.kind == STEP_CFG) begin
						cfg_index <= s.ridx;
						cfg_data <= s.rdata;
						n_we = 1'b1;
					end
					void'(plan.pop_front());
				end
			end
			start <= n_start;
			cfg_we <= n_we;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus plan
	// ---------------------------------------------------------------
	longint plan_sw = 16384, plan_sh = 16384, plan_cw = 1024, plan_ch = 1024;
	longint plan_x [AGENTS];
	longint plan_y [AGENTS];
	int op_cnt = 0;

	function automatic void push_op(op_t op, int id, longint px, longint py,
	                                longint ox, longint oy, longint r);
		grid_step_t s;
		s = '0;
		s.kind = STEP_OP;
		s.op = op;
		s.id = 6'(id);
		s.px = 20'(px);
		s.py = 20'(py);
		s.ox = 20'(ox);
		s.oy = 20'(oy);
		s.r = 19'(r);
		if (op == OP_ADD || op == OP_MOVE) begin
			plan_x[id] = longint'($signed(s.px));
			plan_y[id] = longint'($signed(s.py));
		end
		plan_step(s);
		op_cnt++;
	endfunction

	function automatic void push_drain();
		grid_step_t s;
		s = '0;
		s.kind = STEP_DRAIN;
		plan_step(s);
	endfunction

	function automatic void set_grid(int cols, int rows, longint sw, longint sh,
	                                longint cw, longint ch);
		grid_step_t s;
		longint vals [6];
		vals = '{cols, rows, sw, sh, cw, ch};
		for (int i = 0; i < 6; i++) begin
			s = '0;
			s.kind = STEP_CFG;
			s.ridx = reg_idx_t'(i);
			s.rdata = 19'(vals[i]);
			plan_step(s);
		end
		plan_sw = (sw == 0) ? 1 : sw;
		plan_sh = (sh == 0) ? 1 : sh;
		plan_cw = (cw == 0) ? 1 : cw;
		plan_ch = (ch == 0) ? 1 : ch;
	endfunction

	// mostly inside the grid, now and then anywhere in the 20-bit range
	function automatic longint rand_pos(longint span);
		if ($urandom_range(0, 7) == 0)
			return longint'($signed(20'($urandom)));
		return longint'($urandom_range(0, 32'(span))) - span / 2;
	endfunction

	function automatic longint rand_radius(longint csize);
		longint hi;
		if ($urandom_range(0, 7) == 0)
			return longint'(19'($urandom));
		hi = 3 * csize;
		if (hi > 524287)
			hi = 524287;
		return longint'($urandom_range(0, 32'(hi)));
	endfunction

	function automatic void rand_ops(int count);
		int roll, id;
		longint ox, oy;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			id = $urandom_range(0, AGENTS - 1);
			if (roll < 45) begin
				push_op(OP_ADD, id, rand_pos(plan_sw), rand_pos(plan_sh), 0, 0, 0);
			end else if (roll < 68) begin
				// old position is usually the agent's last one, sometimes a stray
				ox = plan_x[id];
				oy = plan_y[id];
				if ($urandom_range(0, 4) == 0) begin
					ox = rand_pos(plan_sw);
					oy = rand_pos(plan_sh);
				end
				push_op(OP_MOVE, id, rand_pos(plan_sw), rand_pos(plan_sh), ox, oy, 0);
			end else if (roll < 96) begin
				push_op(OP_QUERY, 0, rand_pos(plan_sw), rand_pos(plan_sh), 0, 0,
				        rand_radius(plan_cw > plan_ch ? plan_cw : plan_ch));
			end else begin
				push_op(OP_CLEAR, 0, 0, 0, 0, 0, 0);
			end
		end
	endfunction

	initial begin
		for (int i = 0; i < AGENTS; i++) begin
			plan_x[i] = 0;
			plan_y[i] = 0;
		end

		// Directed: extremes, duplicate add, full cell, moves, radius corners, clear
		push_op(OP_ADD, 0, 0, 0, 0, 0, 0);
		push_op(OP_ADD, 0, 0, 0, 0, 0, 0);
		push_op(OP_ADD, 63, -524288, -524288, 0, 0, 0);
		push_op(OP_ADD, 62, 524287, 524287, 0, 0, 0);
		for (int i = 1; i <= 8; i++)
			push_op(OP_ADD, i, 16 * i, 16, 0, 0, 0);
		push_op(OP_MOVE, 1, 40, 40, 16, 16, 0);
		push_op(OP_MOVE, 2, -3000, -3000, 32, 16, 0);
		push_op(OP_MOVE, 63, 524287, 0, -524288, -524288, 0);
		push_op(OP_QUERY, 0, 0, 0, 0, 0, 0);
		push_op(OP_QUERY, 0, 0, 0, 0, 0, 100);
		push_op(OP_QUERY, 0, 0, 0, 0, 0, 524287);
		push_op(OP_QUERY, 0, -524288, 524287, 0, 0, 524287);
		push_op(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		push_op(OP_QUERY, 0, 0, 0, 0, 0, 524287);

		// Fill the grid with every agent, list some twice, then overflow a query
		for (int i = 0; i < AGENTS; i++)
			push_op(OP_ADD, i, rand_pos(16000), rand_pos(16000), 0, 0, 0);
		for (int i = 0; i < 8; i++)
			push_op(OP_ADD, $urandom_range(0, AGENTS - 1), rand_pos(16000),
			        rand_pos(16000), 0, 0, 0);
		push_op(OP_QUERY, 0, 0, 0, 0, 0, 524287);
		push_drain();
		rand_ops(4);

		// Smallest grid: one cell of unit size
		set_grid(1, 1, 1, 1, 1, 1);
		rand_ops(4);
		// Out-of-range counts and a zero cell width, widest space
		set_grid(0, 31, 524287, 524287, 0, 524287);
		rand_ops(4);
		push_op(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		// Full grid of large cells
		set_grid(16, 16, 524287, 524287, 32768, 32768);
		rand_ops(4);
		// Uneven grid
		set_grid(5, 3, 1000, 600, 200, 200);
		rand_ops(4);

		#1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// hold until the plan is spent and every result has come back
		while (plan.size() > 0 || expected_results.size() > 0 || busy || start)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d operations, %0d results with %0d neighbors, %0d full-cell drops",
		         xfer_cnt, result_cnt, neighbor_cnt, full_cnt);
		$display("over %0d register writes across five grid settings, %0d mismatches",
		         cfg_cnt, errors);
		if (errors == 0 && expected_results.size() == 0)
			$display("uniform_grid_neighbor_search_tb: PASS");
		else
			$display("uniform_grid_neighbor_search_tb: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ugns_pkg.sv
rtl/core/ugns_axis_div.sv
rtl/core/ugns_square.sv
rtl/core/uniform_grid_neighbor_search.sv
rtl/core/ugns_checker.sv
tb/uniform_grid_neighbor_search_tb.sv
